// ===== hw/rtl/obb_pkg.sv =====
// obb_pkg: widths, stage count and word types shared by the box overlap pipeline
// used by obb_dot, obb_sum and obb_overlap_test_2d

package obb_pkg;

    localparam int CoordW   = 16;
    localparam int SizeW    = 15;
    localparam int RotW     = 16;
    localparam int DiffW    = CoordW + 1;
    localparam int AxProdW  = 2 * RotW;
    localparam int AxDotW   = AxProdW + 1;
    localparam int AxMagW   = AxProdW;
    localparam int DProdW   = DiffW + RotW;
    localparam int DDotW    = DProdW + 1;
    localparam int DMagW    = DProdW;
    localparam int ExtProdW = SizeW + AxMagW;
    localparam int CmpW     = 50;
    localparam int OwnShift = 28;
    localparam int LhsShift = 15;
    localparam int NumStg   = 5;
    localparam int NumAxis  = 4;

    // axis slots of the separation test
    localparam int AxArt = 0;
    localparam int AxAup = 1;
    localparam int AxBrt = 2;
    localparam int AxBup = 3;

    typedef struct packed {
        logic [NumStg-1:0] ld;
    } t_pipe_ctl;

    // center distance products and axis cross terms
    typedef struct packed {
        logic signed [DProdW-1:0] xc_a;
        logic signed [DProdW-1:0] ys_a;
        logic signed [DProdW-1:0] xs_a;
        logic signed [DProdW-1:0] yc_a;
        logic signed [DProdW-1:0] xc_b;
        logic signed [DProdW-1:0] ys_b;
        logic signed [DProdW-1:0] xs_b;
        logic signed [DProdW-1:0] yc_b;
        logic [AxMagW-1:0]        pmag;
        logic [AxMagW-1:0]        qmag;
        logic [SizeW-1:0]         aw;
        logic [SizeW-1:0]         ah;
        logic [SizeW-1:0]         bw;
        logic [SizeW-1:0]         bh;
    } t_proj;

    typedef struct packed {
        logic [NumAxis-1:0][CmpW-1:0] lhs;
        logic [NumAxis-1:0][CmpW-1:0] rhs;
    } t_test;

endpackage

// ===== hw/rtl/obb_dot.sv =====
// obb_dot: stages one and two, center difference, rotation cross products,
// center projections; depends on obb_pkg

module obb_dot (
    input  logic                                  i_clk,
    input  obb_pkg::t_pipe_ctl                    i_ctl,
    input  logic signed [obb_pkg::CoordW-1:0]     i_a_center_x,
    input  logic signed [obb_pkg::CoordW-1:0]     i_a_center_y,
    input  logic        [obb_pkg::SizeW-1:0]      i_a_width,
    input  logic        [obb_pkg::SizeW-1:0]      i_a_height,
    input  logic signed [obb_pkg::RotW-1:0]       i_a_cos,
    input  logic signed [obb_pkg::RotW-1:0]       i_a_sin,
    input  logic signed [obb_pkg::CoordW-1:0]     i_b_center_x,
    input  logic signed [obb_pkg::CoordW-1:0]     i_b_center_y,
    input  logic        [obb_pkg::SizeW-1:0]      i_b_width,
    input  logic        [obb_pkg::SizeW-1:0]      i_b_height,
    input  logic signed [obb_pkg::RotW-1:0]       i_b_cos,
    input  logic signed [obb_pkg::RotW-1:0]       i_b_sin,
    output obb_pkg::t_proj                        o_proj
);

    localparam int DW  = obb_pkg::DiffW;
    localparam int APW = obb_pkg::AxProdW;
    localparam int ADW = obb_pkg::AxDotW;
    localparam int AMW = obb_pkg::AxMagW;
    localparam int DPW = obb_pkg::DProdW;

    logic signed [DW-1:0]              r_dx, r_dy;
    logic signed [obb_pkg::RotW-1:0]   r_ac, r_as, r_bc, r_bs;
    logic        [obb_pkg::SizeW-1:0]  r_aw, r_ah, r_bw, r_bh;
    logic signed [APW-1:0]             r_cc, r_ss, r_sc, r_cs;
    obb_pkg::t_proj                    r_proj;

    logic signed [ADW-1:0]             n_p, n_q;
    logic        [AMW-1:0]             n_pmag, n_qmag;

    // stage one
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_dx <= DW'(i_a_center_x) - DW'(i_b_center_x);
            r_dy <= DW'(i_a_center_y) - DW'(i_b_center_y);
            r_ac <= i_a_cos;
            r_as <= i_a_sin;
            r_bc <= i_b_cos;
            r_bs <= i_b_sin;
            r_aw <= i_a_width;
            r_ah <= i_a_height;
            r_bw <= i_b_width;
            r_bh <= i_b_height;
            r_cc <= APW'(i_a_cos) * APW'(i_b_cos);
            r_ss <= APW'(i_a_sin) * APW'(i_b_sin);
            r_sc <= APW'(i_a_sin) * APW'(i_b_cos);
            r_cs <= APW'(i_a_cos) * APW'(i_b_sin);
        end
    end

    // p = right_a . right_b, q = right_a . up_b
    always_comb begin
        n_p    = ADW'(r_cc) + ADW'(r_ss);
        n_q    = ADW'(r_sc) - ADW'(r_cs);
        n_pmag = n_p[ADW-1] ? AMW'(-n_p) : AMW'(n_p);
        n_qmag = n_q[ADW-1] ? AMW'(-n_q) : AMW'(n_q);
    end

    // stage two
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[1]) begin
            r_proj.xc_a <= DPW'(r_dx) * DPW'(r_ac);
            r_proj.ys_a <= DPW'(r_dy) * DPW'(r_as);
            r_proj.xs_a <= DPW'(r_dx) * DPW'(r_as);
            r_proj.yc_a <= DPW'(r_dy) * DPW'(r_ac);
            r_proj.xc_b <= DPW'(r_dx) * DPW'(r_bc);
            r_proj.ys_b <= DPW'(r_dy) * DPW'(r_bs);
            r_proj.xs_b <= DPW'(r_dx) * DPW'(r_bs);
            r_proj.yc_b <= DPW'(r_dy) * DPW'(r_bc);
            r_proj.pmag <= n_pmag;
            r_proj.qmag <= n_qmag;
            r_proj.aw   <= r_aw;
            r_proj.ah   <= r_ah;
            r_proj.bw   <= r_bw;
            r_proj.bh   <= r_bh;
        end
    end

    assign o_proj = r_proj;

endmodule

// ===== hw/rtl/obb_sum.sv =====
// obb_sum: stages three and four, projection magnitudes, extent products,
// both sides of each axis test; depends on obb_pkg

module obb_sum (
    input  logic               i_clk,
    input  obb_pkg::t_pipe_ctl i_ctl,
    input  obb_pkg::t_proj     i_proj,
    output obb_pkg::t_test     o_test
);

    localparam int DDW = obb_pkg::DDotW;
    localparam int DMW = obb_pkg::DMagW;
    localparam int EPW = obb_pkg::ExtProdW;
    localparam int CW  = obb_pkg::CmpW;
    localparam int NA  = obb_pkg::NumAxis;

    logic signed [NA-1:0][DDW-1:0]     n_dot;
    logic        [NA-1:0][DMW-1:0]     n_dmag;
    logic        [NA-1:0][DMW-1:0]     r_dmag;
    logic [EPW-1:0] r_bhq, r_bwp, r_bhp, r_bwq, r_ahq, r_awp, r_ahp, r_awq;
    logic [obb_pkg::SizeW-1:0]         r_aw, r_ah, r_bw, r_bh;
    obb_pkg::t_test                    r_test;

    always_comb begin
        n_dot[obb_pkg::AxArt] = DDW'(i_proj.xc_a) + DDW'(i_proj.ys_a);
        n_dot[obb_pkg::AxAup] = DDW'(i_proj.yc_a) - DDW'(i_proj.xs_a);
        n_dot[obb_pkg::AxBrt] = DDW'(i_proj.xc_b) + DDW'(i_proj.ys_b);
        n_dot[obb_pkg::AxBup] = DDW'(i_proj.yc_b) - DDW'(i_proj.xs_b);
        for (int k = 0; k < NA; k++) begin
            n_dmag[k] = n_dot[k][DDW-1] ? DMW'(-n_dot[k]) : DMW'(n_dot[k]);
        end
    end

    // stage three
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[2]) begin
            r_dmag <= n_dmag;
            r_bhq  <= EPW'(i_proj.bh) * EPW'(i_proj.qmag);
            r_bwp  <= EPW'(i_proj.bw) * EPW'(i_proj.pmag);
            r_bhp  <= EPW'(i_proj.bh) * EPW'(i_proj.pmag);
            r_bwq  <= EPW'(i_proj.bw) * EPW'(i_proj.qmag);
            r_ahq  <= EPW'(i_proj.ah) * EPW'(i_proj.qmag);
            r_awp  <= EPW'(i_proj.aw) * EPW'(i_proj.pmag);
            r_ahp  <= EPW'(i_proj.ah) * EPW'(i_proj.pmag);
            r_awq  <= EPW'(i_proj.aw) * EPW'(i_proj.qmag);
            r_aw   <= i_proj.aw;
            r_ah   <= i_proj.ah;
            r_bw   <= i_proj.bw;
            r_bh   <= i_proj.bh;
        end
    end

    // stage four
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[3]) begin
            for (int k = 0; k < NA; k++) begin
                r_test.lhs[k] <= CW'(r_dmag[k]) << obb_pkg::LhsShift;
            end
            r_test.rhs[obb_pkg::AxArt] <= CW'(r_bhq) + CW'(r_bwp)
                                        + (CW'(r_aw) << obb_pkg::OwnShift);
            r_test.rhs[obb_pkg::AxAup] <= CW'(r_bhp) + CW'(r_bwq)
                                        + (CW'(r_ah) << obb_pkg::OwnShift);
            r_test.rhs[obb_pkg::AxBrt] <= CW'(r_ahq) + CW'(r_awp)
                                        + (CW'(r_bw) << obb_pkg::OwnShift);
            r_test.rhs[obb_pkg::AxBup] <= CW'(r_ahp) + CW'(r_awq)
                                        + (CW'(r_bh) << obb_pkg::OwnShift);
        end
    end

    assign o_test = r_test;

endmodule

// ===== hw/rtl/obb_overlap_test_2d.sv =====
// obb_overlap_test_2d: separating axis overlap test for two oriented boxes
// depends on obb_pkg, obb_dot and obb_sum
//
//   channel | direction | handshake          | payload
//   box pair| in        | i_valid / o_stall  | i_a_* , i_b_* (12 fields)
//   result  | out       | o_valid / i_stall  | o_overlap
//
// five register stages, one word per cycle sustained while the output is not stalled
// every stage takes a new word each cycle unless stalled, the five stages set the latency only
// stages with no valid word fill while the output is stalled, so bubbles close up
// reset clears the valid bits only, data registers are not reset

module obb_overlap_test_2d (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [obb_pkg::CoordW-1:0] i_a_center_x,
    input  logic signed [obb_pkg::CoordW-1:0] i_a_center_y,
    input  logic        [obb_pkg::SizeW-1:0]  i_a_width,
    input  logic        [obb_pkg::SizeW-1:0]  i_a_height,
    input  logic signed [obb_pkg::RotW-1:0]   i_a_cos,
    input  logic signed [obb_pkg::RotW-1:0]   i_a_sin,
    input  logic signed [obb_pkg::CoordW-1:0] i_b_center_x,
    input  logic signed [obb_pkg::CoordW-1:0] i_b_center_y,
    input  logic        [obb_pkg::SizeW-1:0]  i_b_width,
    input  logic        [obb_pkg::SizeW-1:0]  i_b_height,
    input  logic signed [obb_pkg::RotW-1:0]   i_b_cos,
    input  logic signed [obb_pkg::RotW-1:0]   i_b_sin,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_overlap
);

    localparam int NS = obb_pkg::NumStg;

    logic [NS-1:0]      r_v, n_v;
    logic [NS-1:0]      stage_rdy;
    obb_pkg::t_pipe_ctl ctl;
    obb_pkg::t_proj     proj;
    obb_pkg::t_test     test;
    logic               r_overlap;
    logic               sep;

    always_comb begin
        stage_rdy[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_rdy[k] = !r_v[k] || stage_rdy[k+1];
        end
        ctl.ld[0] = stage_rdy[0] && i_valid;
        n_v[0]    = stage_rdy[0] ? i_valid : r_v[0];
        for (int k = 1; k < NS; k++) begin
            ctl.ld[k] = stage_rdy[k] && r_v[k-1];
            n_v[k]    = stage_rdy[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    obb_dot u_dot (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_a_center_x (i_a_center_x),
        .i_a_center_y (i_a_center_y),
        .i_a_width    (i_a_width),
        .i_a_height   (i_a_height),
        .i_a_cos      (i_a_cos),
        .i_a_sin      (i_a_sin),
        .i_b_center_x (i_b_center_x),
        .i_b_center_y (i_b_center_y),
        .i_b_width    (i_b_width),
        .i_b_height   (i_b_height),
        .i_b_cos      (i_b_cos),
        .i_b_sin      (i_b_sin),
        .o_proj       (proj)
    );

    obb_sum u_sum (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_proj (proj),
        .o_test (test)
    );

    // any strict excess separates
    always_comb begin
        sep = 1'b0;
        for (int k = 0; k < obb_pkg::NumAxis; k++) begin
            sep = sep | (test.lhs[k] > test.rhs[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld[NS-1]) begin
            r_overlap <= !sep;
        end
    end

    assign o_stall   = !stage_rdy[0];
    assign o_valid   = r_v[NS-1];
    assign o_overlap = r_overlap;

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v[0])
        else $error("input stalled with empty first stage");

    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule
